// ===== rtl/core/tsid_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsid_pkg: shared constants, types and helpers
// Widths, generator constants and the base-64 character map of the
// timestamp ID generator.
// ----------------------------------------------------------------------------
package tsid_pkg;

  // Field and digit widths
  localparam int unsigned TimeW      = 64;
  localparam int unsigned TimeEncW   = 48;
  localparam int unsigned SuffixW    = 72;
  localparam int unsigned SeedW      = 48;
  localparam int unsigned DigitW     = 6;
  localparam int unsigned CharW      = 7;
  localparam int unsigned IdChars    = 20;
  localparam int unsigned CharCntW   = 5;
  localparam int unsigned PayloadW   = TimeEncW + SuffixW;

  // 48-bit linear congruential generator
  localparam logic [SeedW-1:0] SeedReset  = 48'd20017429951246;
  localparam int unsigned      LcgDigits  = 9;
  localparam logic [35:0]      LcgMul     = 36'h5DEECE66D;
  localparam logic [SeedW-1:0] LcgAdd     = 48'hB;
  localparam int unsigned      DrawW      = 31;
  localparam int unsigned      DrawShift  = 17;
  localparam int unsigned      DrawsPerId = 3;

  // Load request from the control path to the serializer
  typedef struct packed {
    logic                valid;
    logic [TimeEncW-1:0] time_bits;
    logic [SuffixW-1:0]  suffix;
  } tsid_load_t;

  // Control of the generator unit
  typedef struct packed {
    logic start;
    logic seed_we;
  } tsid_lcg_ctl_t;

  // Map one 6-bit digit to its character of the sortable alphabet
  function automatic logic [CharW-1:0] digit_to_char(logic [DigitW-1:0] d);
    logic [CharW-1:0] dd;
    dd = {1'b0, d};
    if (d == 6'd0) begin
      return 7'd45;            // dash
    end else if (d <= 6'd10) begin
      return dd + 7'd47;       // digits 0..9
    end else if (d <= 6'd36) begin
      return dd + 7'd54;       // upper case letters
    end else if (d == 6'd37) begin
      return 7'd95;            // underscore
    end else begin
      return dd + 7'd59;       // lower case letters
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tsid_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsid_if: channel interfaces
// Valid/ready channels for timestamp items and ID character items.
// ----------------------------------------------------------------------------
interface tsid_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] timestamp;

  modport source (output valid, output timestamp, input ready);
  modport sink   (input valid, input timestamp, output ready);
endinterface

interface tsid_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] id_char;
  logic       last_char;

  modport source (output valid, output id_char, output last_char, input ready);
  modport sink   (input valid, input id_char, input last_char, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tsid_lcg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsid_lcg: nibble-serial 48-bit LCG
// Steps x' = a*x + c mod 2^48 one 4-bit digit of the multiplier per cycle,
// most significant digit first.
// ----------------------------------------------------------------------------
module tsid_lcg
  import tsid_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tsid_lcg_ctl_t    ctl_i,
  input  wire logic [SeedW-1:0] seed_i,
  output logic                  done_o,
  output logic [DrawW-1:0]      draw_o
);

  logic [SeedW-1:0] x_q, x_d;
  logic [SeedW-1:0] acc_q, acc_d;
  logic [3:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [3:0]       nib;
  logic [SeedW-1:0] prod;
  logic [SeedW-1:0] step;

  // Multiply-accumulate one multiplier digit (Horner form)
  always_comb begin
    nib  = LcgMul[{cnt_q, 2'b00} +: 4];
    prod = x_q * SeedW'(nib);
    step = {acc_q[SeedW-5:0], 4'b0000} + prod + ((cnt_q == 4'd0) ? LcgAdd : '0);
  end

  // Sequence the digits
  always_comb begin
    x_d    = x_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctl_i.seed_we) begin
      x_d = seed_i;
    end else if (ctl_i.start) begin
      acc_d  = '0;
      cnt_d  = 4'(LcgDigits - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = step;
      if (cnt_q == 4'd0) begin
        x_d    = step;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= SeedReset;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      x_q    <= x_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Hold the partial product
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign draw_o = x_q[SeedW-1:DrawShift];

endmodule
`default_nettype wire

// ===== rtl/core/tsid_ser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsid_ser: ID character serializer
// Shifts the 120-bit ID word out one 6-bit digit per item, most
// significant first, mapping each digit to its character.
// ----------------------------------------------------------------------------
module tsid_ser
  import tsid_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire tsid_load_t load_i,
  output logic            load_ready_o,
  tsid_out_if.source      id_o
);

  logic [PayloadW-1:0] sh_q, sh_d;
  logic [CharCntW-1:0] cnt_q, cnt_d;
  logic                valid_q, valid_d;
  logic                last;
  logic                take;

  assign last         = (cnt_q == CharCntW'(IdChars - 1));
  assign take         = valid_q && id_o.ready;
  assign load_ready_o = !valid_q || (take && last);

  // Load a new word, advance on each taken item, drop valid after the last
  always_comb begin
    sh_d    = sh_q;
    cnt_d   = cnt_q;
    valid_d = valid_q;
    if (load_i.valid && load_ready_o) begin
      sh_d    = {load_i.time_bits, load_i.suffix};
      cnt_d   = '0;
      valid_d = 1'b1;
    end else if (take) begin
      if (last) begin
        valid_d = 1'b0;
      end else begin
        sh_d  = {sh_q[PayloadW-DigitW-1:0], {DigitW{1'b0}}};
        cnt_d = cnt_q + CharCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign id_o.valid     = valid_q;
  assign id_o.id_char   = digit_to_char(sh_q[PayloadW-1 -: DigitW]);
  assign id_o.last_char = last;

endmodule
`default_nettype wire

// ===== rtl/core/timestamp_random_id_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// timestamp_random_id_generator: time-ordered ID generator
// Turns each timestamp item into a 20-character sortable ID.
// ----------------------------------------------------------------------------
// Usage:
//   ts_i  takes one signed 64-bit timestamp per item (valid/ready).
//   id_o  gives 20 character items per timestamp, first character first;
//         last_char marks the twentieth.
//   cfg_we_i/cfg_wdata_i load the 48-bit generator state; write only while
//   the block is idle.
// Flow: a repeated timestamp bumps the suffix and goes straight to the load
//   state; a new timestamp first runs three generator draws (one 4-bit
//   multiplier digit per cycle) to refill the suffix.
// Throughput: one character per cycle while id_o.ready is high, set by the
//   serializer for repeated timestamps; new timestamps are paced by the
//   nibble-serial generator. The next timestamp is accepted while the
//   previous ID is still being sent.
// Reset: previous time and suffix clear, the generator takes its default
//   seed, no item is pending.
// Stall: while id_o.ready is low the current character holds and the next
//   finished ID waits in the control path.
// ----------------------------------------------------------------------------
module timestamp_random_id_generator
  import tsid_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  tsid_in_if.sink               ts_i,
  tsid_out_if.source            id_o,
  input  wire logic             cfg_we_i,
  input  wire logic [SeedW-1:0] cfg_wdata_i
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDraw = 3'b010,
    StLoad = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [TimeW-1:0]    prev_q, prev_d;
  logic [SuffixW-1:0]  suffix_q, suffix_d;
  logic [TimeEncW-1:0] ts_q, ts_d;
  logic [1:0]          draw_cnt_q, draw_cnt_d;
  logic                accept;
  logic                same_time;
  tsid_lcg_ctl_t       lcg_ctl;
  logic                lcg_done;
  logic [DrawW-1:0]    draw;
  tsid_load_t          load;
  logic                load_ready;

  assign ts_i.ready = (state_q == StIdle);
  assign accept     = ts_i.valid && ts_i.ready;
  assign same_time  = ($unsigned(ts_i.timestamp) == prev_q);

  // Control: compare, refill or bump the suffix, hand the word over
  always_comb begin
    state_d         = state_q;
    prev_d          = prev_q;
    suffix_d        = suffix_q;
    ts_d            = ts_q;
    draw_cnt_d      = draw_cnt_q;
    lcg_ctl.start   = 1'b0;
    lcg_ctl.seed_we = cfg_we_i;
    load.valid      = (state_q == StLoad);
    load.time_bits  = ts_q;
    load.suffix     = suffix_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          ts_d = ts_i.timestamp[TimeEncW-1:0];
          if (same_time) begin
            suffix_d = suffix_q + SuffixW'(1);
            state_d  = StLoad;
          end else begin
            prev_d        = $unsigned(ts_i.timestamp);
            draw_cnt_d    = '0;
            lcg_ctl.start = 1'b1;
            state_d       = StDraw;
          end
        end
      end
      StDraw: begin
        if (lcg_done) begin
          suffix_d = {suffix_q[SuffixW-25:0], draw[7:0], draw[15:8], draw[23:16]};
          if (draw_cnt_q == 2'(DrawsPerId - 1)) begin
            state_d = StLoad;
          end else begin
            draw_cnt_d    = draw_cnt_q + 2'd1;
            lcg_ctl.start = 1'b1;
          end
        end
      end
      StLoad: begin
        if (load_ready) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      prev_q     <= '0;
      suffix_q   <= '0;
      draw_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      prev_q     <= prev_d;
      suffix_q   <= suffix_d;
      draw_cnt_q <= draw_cnt_d;
    end
  end

  // Hold the timestamp bits to encode
  always_ff @(posedge clk_i) begin
    ts_q <= ts_d;
  end

  tsid_lcg u_lcg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (lcg_ctl),
    .seed_i (cfg_wdata_i),
    .done_o (lcg_done),
    .draw_o (draw)
  );

  tsid_ser u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .load_ready_o (load_ready),
    .id_o         (id_o)
  );

  // A new timestamp is remembered as the previous one
  a_prev_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> prev_q == $past($unsigned(ts_i.timestamp)))
    else $error("previous time not updated");

  // Draws complete only while a refill is under way
  a_draw_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lcg_done |-> state_q == StDraw)
    else $error("generator draw outside refill");

  // A word is handed over only when the serializer is free or ends its ID
  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load.valid && load_ready) |-> (!id_o.valid || (id_o.ready && id_o.last_char)))
    else $error("serializer overwritten mid ID");

  // Each refill makes exactly three draws
  a_draw_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDraw && state_d == StLoad) |-> draw_cnt_q == 2'(DrawsPerId - 1))
    else $error("wrong number of draws");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: timestamp ID generator testbench
// Feeds timestamps through the valid/ready input and checks every ID
// character on the output against a cycle-free predictor of the ID scheme:
// eight time digits, then a twelve-digit suffix that is refilled from the
// 48-bit generator on a new timestamp or counts up on a repeated one.
// Both sides idle at random, and the generator seed is reloaded between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import tsid_pkg::*;

  localparam logic [47:0] LCG_MULT      = 48'h5_DEEC_E66D;
  localparam logic [47:0] LCG_INC       = 48'hB;
  localparam logic [47:0] SEED_DEFAULT  = 48'd20017429951246;
  localparam int          CHARS_PER_ID  = 20;
  localparam int          TIME_DIGITS   = 8;
  localparam int          IDLE_SETTLE   = 40;
  localparam int          END_SETTLE    = 60;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          HOLD_AFTER    = 900;
  localparam int          RANDOM_PHASES = 4;
  localparam int          PHASE_ITEMS   = 25;
  localparam int          NUM_ROWS      = 23;

  typedef enum logic [1:0] {
    ROW_TS,
    ROW_SEED,
    ROW_CARRY_SEED
  } row_kind_e;

  // One directed row; id_text of all zeros leaves the ID to the predictor
  typedef struct packed {
    row_kind_e     kind;
    logic [63:0]   value;
    logic [159:0]  id_text;
  } stim_row_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       last_flag;
  } id_char_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [SeedW-1:0] cfg_wdata;

  tsid_in_if  ts_if ();
  tsid_out_if id_if ();

  timestamp_random_id_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ts_i        (ts_if),
    .id_o        (id_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state; the alphabet is dash, digits, upper case, underscore, lower case
  string       SORT_ALPHABET = {"-0123456789", "ABCDEFGHIJKLMNOPQRSTUVWXYZ", "_",
                                "abcdefghijklmnopqrstuvwxyz"};
  logic [63:0] prior_time;
  logic [71:0] suffix_val;
  logic [47:0] lcg_state;
  id_char_t    expected_chars [$];

  int unsigned fail_count    = 0;
  int unsigned chars_checked = 0;
  int unsigned ids_checked   = 0;
  int unsigned items_sent    = 0;
  int unsigned seeds_loaded  = 0;
  int unsigned burst_left    = 0;

  // Directed rows: after reset, extremes, high-bit-only changes, suffix carry
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_TS, 64'h0000_0000_0000_0000, {"--------", "-----------0"}},
    '{ROW_TS, 64'h0000_0000_0000_0000, {"--------", "-----------1"}},
    '{ROW_TS, 64'h0000_0000_0000_0000, {"--------", "-----------2"}},
    '{ROW_TS, 64'h0000_FFFF_FFFF_FFFF, '0},
    '{ROW_TS, 64'h0000_FFFF_FFFF_FFFF, '0},
    '{ROW_TS, 64'hFFFF_FFFF_FFFF_FFFF, '0},
    '{ROW_TS, 64'h8000_0000_0000_0000, '0},
    '{ROW_TS, 64'h7FFF_FFFF_FFFF_FFFF, '0},
    '{ROW_TS, 64'h0000_0000_0000_0001, '0},
    '{ROW_TS, 64'h0000_8000_0000_0000, '0},
    '{ROW_TS, 64'h5555_5555_5555_5555, '0},
    '{ROW_TS, 64'hAAAA_AAAA_AAAA_AAAA, '0},
    '{ROW_TS, 64'h5555_AAAA_AAAA_AAAA, '0},
    '{ROW_CARRY_SEED, 64'h0, '0},
    '{ROW_TS, 64'h0123_4567_89AB_CDEF, '0},
    '{ROW_TS, 64'h0123_4567_89AB_CDEF, '0},
    '{ROW_TS, 64'h0123_4567_89AB_CDEF, '0},
    '{ROW_SEED, 64'h0, '0},
    '{ROW_TS, 64'h0000_0000_0000_0000, '0},
    '{ROW_TS, 64'h0000_0000_0000_0000, '0},
    '{ROW_SEED, 64'h0000_FFFF_FFFF_FFFF, '0},
    '{ROW_TS, 64'hFEDC_BA98_7654_3210, '0},
    '{ROW_TS, 64'hFEDC_BA98_7654_3210, '0}
  };

  // Advance the ID state for one timestamp and queue its twenty characters
  function automatic void predict_id(input logic [63:0] t, input logic [159:0] typed_id);
    logic [30:0] draw;
    logic [5:0]  digit;
    byte         glyph;
    id_char_t    item;
    if (t != prior_time) begin
      prior_time = t;
      for (int d = 0; d < 3; d++) begin
        lcg_state = lcg_state * LCG_MULT + LCG_INC;
        draw = lcg_state[47:17];
        for (int b = 0; b < 3; b++) begin
          suffix_val = {suffix_val[63:0], draw[8*b +: 8]};
        end
      end
    end else begin
      suffix_val = suffix_val + 72'd1;
    end
    for (int k = 0; k < CHARS_PER_ID; k++) begin
      if (k < TIME_DIGITS) begin
        digit = t[47 - 6*k -: 6];
      end else begin
        digit = suffix_val[71 - 6*(k - TIME_DIGITS) -: 6];
      end
      glyph = SORT_ALPHABET[digit];
      item.ch = (typed_id == '0) ? glyph[6:0] : typed_id[158 - 8*k -: 7];
      item.last_flag = (k == CHARS_PER_ID - 1);
      expected_chars.push_back(item);
    end
  endfunction

  // Step the generator back by one draw (modular inverse of the multiplier)
  function automatic logic [47:0] rewind_lcg(input logic [47:0] x);
    logic [47:0] inv;
    inv = LCG_MULT;
    for (int i = 0; i < 5; i++) begin
      inv = inv * (48'd2 - LCG_MULT * inv);
    end
    return (x - LCG_INC) * inv;
  endfunction

  // Mix of repeats, extremes, high-bit-only changes, small and wide values
  function automatic logic [63:0] pick_timestamp();
    int unsigned sel;
    logic [63:0] wide;
    sel  = $urandom_range(0, 99);
    wide = {$urandom, $urandom};
    if (sel < 35) begin
      return prior_time;
    end else if (sel < 50) begin
      case ($urandom_range(0, 4))
        0:       return 64'h0000_0000_0000_0000;
        1:       return 64'hFFFF_FFFF_FFFF_FFFF;
        2:       return 64'h7FFF_FFFF_FFFF_FFFF;
        3:       return 64'h8000_0000_0000_0000;
        default: return 64'h0000_FFFF_FFFF_FFFF;
      endcase
    end else if (sel < 65) begin
      return {wide[63:48], prior_time[47:0]};
    end else if (sel < 75) begin
      return 64'($urandom_range(0, 255));
    end
    return wide;
  endfunction

  // Offer one timestamp, in bursts with random gaps; called at a falling edge
  task automatic offer_timestamp(input logic [63:0] t, input logic [159:0] typed_id);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        ts_if.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    ts_if.valid     = 1'b1;
    ts_if.timestamp = t;
    do @(posedge clk_i); while (ts_if.ready !== 1'b1);
    predict_id(t, typed_id);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Drain every ID, let the block settle, then load a new generator seed
  task automatic load_seed(input logic [47:0] seed);
    ts_if.valid = 1'b0;
    burst_left  = 0;
    while (expected_chars.size() != 0) @(negedge clk_i);
    repeat (IDLE_SETTLE) @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = seed;
    @(negedge clk_i);
    cfg_we    = 1'b0;
    lcg_state = seed;
    seeds_loaded++;
  endtask

  // Stimulus: reset, directed rows, random phases, drain and verdict
  initial begin : stimulus
    logic [47:0] seed;
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    ts_if.valid     = 1'b0;
    ts_if.timestamp = '0;
    prior_time      = '0;
    suffix_val      = '0;
    lcg_state       = SEED_DEFAULT;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < NUM_ROWS; r++) begin
      case (directed_rows[r].kind)
        ROW_TS: begin
          offer_timestamp(directed_rows[r].value, directed_rows[r].id_text);
        end
        ROW_SEED: begin
          load_seed(directed_rows[r].value[47:0]);
        end
        ROW_CARRY_SEED: begin
          // Pick a seed whose third draw fills the low suffix bytes with ones
          seed = 48'({$urandom, $urandom});
          seed[40:17] = 24'hFF_FFFF;
          repeat (3) seed = rewind_lcg(seed);
          load_seed(seed);
        end
        default: begin
          $error("unknown directed row kind at row %0d", r);
          fail_count++;
        end
      endcase
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        1:       load_seed(SEED_DEFAULT);
        default: load_seed(48'({$urandom, $urandom}));
      endcase
      repeat (PHASE_ITEMS) offer_timestamp(pick_timestamp(), '0);
    end

    ts_if.valid = 1'b0;
    while (expected_chars.size() != 0) @(negedge clk_i);
    repeat (END_SETTLE) @(negedge clk_i);
    $display("Covered %0d timestamps over %0d seed loads; %0d IDs, %0d characters compared.",
             items_sent, seeds_loaded, ids_checked, chars_checked);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Receiver: stall on shifting patterns, with one long hold to back up the block
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    bit          held;
    held        = 1'b0;
    id_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && chars_checked >= HOLD_AFTER) begin
        held = 1'b1;
        @(negedge clk_i);
        id_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          0:       id_if.ready = 1'b1;
          1:       id_if.ready = 1'($urandom_range(0, 1));
          2:       id_if.ready = ($urandom_range(0, 3) == 0);
          default: id_if.ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Compare each accepted character with the oldest expectation
  always @(posedge clk_i) begin : id_check
    id_char_t want;
    if (rst_ni && id_if.valid === 1'b1 && id_if.ready === 1'b1) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character: id_char %0d last_char %0b",
               id_if.id_char, id_if.last_char);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (id_if.id_char !== want.ch) begin
          $error("id_char: expected %0d ('%c') got %0d", want.ch, want.ch, id_if.id_char);
          fail_count++;
        end
        if (id_if.last_char !== want.last_flag) begin
          $error("last_char: expected %0b got %0b", want.last_flag, id_if.last_char);
          fail_count++;
        end
        if (want.last_flag) begin
          ids_checked++;
        end
      end
    end
  end

  // Hard stop if the run hangs
  initial begin : watchdog
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
